>>> src/hbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
`default_nettype none

package hbp_pkg;

    // Field widths fixed by the item format.
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int ENTRY_W = CODE_W + LEN_W;
    // Staging word: up to seven pending bits plus a full 32-bit code, rounded to bytes.
    localparam int WORD_W  = 40;
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;
    localparam int LEFT_W  = 3;

    // Item operations.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // Result kinds.
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Looked-up item handed from the table stage to the packer.
    typedef struct packed {
        logic                vld;
        t_opcode             op;
        logic                hit;
        logic [LEN_W-1:0]    len;
        logic [CODE_W-1:0]   bits;
    } t_lookup;

endpackage

`default_nettype wire

>>> src/huffman_code_bit_packer.sv
// The lookup stage registers each input beat; its result bytes then leave from
// the staging word. Throughput: one input beat per cycle unless the lookup stage
// stalls; an item's k result bytes (at most four) hold the output, one byte per beat.
// Reset: synchronous, active low; the code table valid bits clear at once, so
// all symbols read as having no code, with no clearing pass.
`default_nettype none

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [7:0]                  i_symbol,
    input  wire logic [hbp_pkg::CODE_W-1:0]  i_code_value,
    input  wire logic [hbp_pkg::LEN_W-1:0]   i_code_length,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_kind,
    output logic                             o_last
);

    hbp_pkg::t_lookup lookup;
    logic             advance;

    // Table intake and lookup.
    hbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .i_advance     (advance),
        .o_lookup      (lookup)
    );

    // Packing and byte output.
    hbp_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lookup   (lookup),
        .o_advance  (advance),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    // An error result is always a single, final, zero byte.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == hbp_pkg::KIND_ERROR) |-> o_last && (o_out_byte == 8'd0))
        else $error("error result not a single zero byte");

    // Intake stalls only behind an item held in the lookup stage.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> lookup.vld)
        else $error("intake stalled with empty lookup stage");

    // A held lookup item stays until it advances.
    a_lookup_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lookup.vld && !advance |=> lookup.vld && $stable(lookup.op))
        else $error("lookup item lost while stalled");

endmodule

`default_nettype wire

>>> src/hbp_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/hbp_table.sv
// Code table stage: input beat intake, table writes, and table lookups.
`default_nettype none

module hbp_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [7:0]                    i_symbol,
    input  wire logic [hbp_pkg::CODE_W-1:0]    i_code_value,
    input  wire logic [hbp_pkg::LEN_W-1:0]     i_code_length,
    input  wire logic                          i_advance,
    output hbp_pkg::t_lookup                   o_lookup
);

    localparam int IDX_W     = $clog2(SYMBOL_COUNT);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < hbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                : hbp_pkg::CODE_W;

    logic                           accept;
    logic                           in_range;
    logic [IDX_W-1:0]               idx;
    logic [hbp_pkg::LEN_W-1:0]      len_sat;
    logic [hbp_pkg::CODE_W-1:0]     mask;
    logic                           we;
    logic                           re;
    logic [hbp_pkg::ENTRY_W-1:0]    rdata;
    hbp_pkg::t_opcode               op_in;

    logic                           r_s1_vld;
    hbp_pkg::t_opcode               r_s1_op;
    logic                           r_s1_hit;
    logic [SYMBOL_COUNT-1:0]        r_valid;

    // The stage takes a new beat when empty or when its item moves on.
    assign o_ready  = !r_s1_vld || i_advance;
    assign accept   = i_valid && o_ready;
    assign op_in    = hbp_pkg::t_opcode'(i_opcode);
    assign in_range = ({1'b0, i_symbol} < 9'(SYMBOL_COUNT));
    assign idx      = i_symbol[IDX_W-1:0];

    // Saturate the loaded length and drop code bits above it.
    always_comb begin
        len_sat = (i_code_length > hbp_pkg::LEN_W'(LEN_LIMIT))
                ? hbp_pkg::LEN_W'(LEN_LIMIT) : i_code_length;
        if (len_sat >= hbp_pkg::LEN_W'(hbp_pkg::CODE_W)) begin
            mask = '1;
        end else begin
            mask = hbp_pkg::CODE_W'((33'd1 << len_sat) - 33'd1);
        end
    end

    assign we = accept && (op_in == hbp_pkg::OP_LOAD) && in_range;
    assign re = accept && (op_in == hbp_pkg::OP_ENCODE);

    hbp_ram #(
        .WIDTH (hbp_pkg::ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (idx),
        .i_wdata ({len_sat, i_code_value & mask}),
        .i_re    (re),
        .i_raddr (idx),
        .o_rdata (rdata)
    );

    // Per-entry valid bits: an entry never written reads as having no code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[idx] <= 1'b1;
        end
    end

    // Lookup stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= op_in;
            r_s1_hit <= in_range && r_valid[idx];
        end
    end

    always_comb begin
        o_lookup.vld  = r_s1_vld;
        o_lookup.op   = r_s1_op;
        o_lookup.hit  = r_s1_hit;
        o_lookup.len  = rdata[hbp_pkg::ENTRY_W-1:hbp_pkg::CODE_W];
        o_lookup.bits = rdata[hbp_pkg::CODE_W-1:0];
    end

endmodule

`default_nettype wire

>>> src/hbp_pack.sv
// Bit packer: pending-bit accumulator and byte emitter.
`default_nettype none

module hbp_pack (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hbp_pkg::t_lookup  i_lookup,
    output logic                   o_advance,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_kind,
    output logic                   o_last
);

    logic [hbp_pkg::WORD_W-1:0]  acc;
    logic [hbp_pkg::WORD_W-1:0]  aligned;
    logic [hbp_pkg::LEN_W-1:0]   total;
    logic [hbp_pkg::LEN_W-1:0]   lshift;
    logic [hbp_pkg::PEND_W-1:0]  keep_mask;
    logic [7:0]                  flush_byte;
    logic                        is_error;
    logic [hbp_pkg::LEFT_W-1:0]  n_res;
    logic [hbp_pkg::WORD_W-1:0]  n_load_word;
    logic                        n_load_kind;
    logic                        emit_free;
    logic                        beat;

    logic [hbp_pkg::PEND_W-1:0]  r_pend_bits;
    logic [hbp_pkg::CNT_W-1:0]   r_pend_cnt;
    logic [hbp_pkg::WORD_W-1:0]  r_word;
    logic [hbp_pkg::LEFT_W-1:0]  r_left;
    logic                        r_kind;

    // Append the code behind the pending bits and left-align the result.
    always_comb begin
        acc        = (hbp_pkg::WORD_W'(r_pend_bits) << i_lookup.len)
                   | hbp_pkg::WORD_W'(i_lookup.bits);
        total      = hbp_pkg::LEN_W'(r_pend_cnt) + i_lookup.len;
        lshift     = hbp_pkg::LEN_W'(hbp_pkg::WORD_W) - total;
        aligned    = acc << lshift;
        keep_mask  = ~(hbp_pkg::PEND_W'('1) << total[2:0]);
        flush_byte = 8'({1'b0, r_pend_bits} << (4'd8 - 4'(r_pend_cnt)));
        is_error   = !i_lookup.hit || (i_lookup.len == '0);
    end

    // Results caused by the item in the lookup stage.
    always_comb begin
        n_res       = '0;
        n_load_word = aligned;
        n_load_kind = hbp_pkg::KIND_DATA;
        unique case (i_lookup.op)
            hbp_pkg::OP_ENCODE: begin
                if (is_error) begin
                    n_res       = hbp_pkg::LEFT_W'(1);
                    n_load_word = '0;
                    n_load_kind = hbp_pkg::KIND_ERROR;
                end else begin
                    n_res = total[5:3];
                end
            end
            hbp_pkg::OP_FLUSH: begin
                n_res       = (r_pend_cnt != '0) ? hbp_pkg::LEFT_W'(1) : '0;
                n_load_word = {flush_byte, (hbp_pkg::WORD_W - 8)'(0)};
            end
            hbp_pkg::OP_LOAD,
            hbp_pkg::OP_NONE: begin
                n_res = '0;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // The emitter can take new results once its last byte leaves.
    assign beat      = o_valid && i_ready;
    assign emit_free = (r_left == '0) || ((r_left == hbp_pkg::LEFT_W'(1)) && i_ready);
    assign o_advance = i_lookup.vld && ((n_res == '0) || emit_free);

    // Pending bits update as the item leaves the lookup stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (o_advance) begin
            if (i_lookup.op == hbp_pkg::OP_ENCODE && !is_error) begin
                r_pend_bits <= acc[hbp_pkg::PEND_W-1:0] & keep_mask;
                r_pend_cnt  <= total[2:0];
            end else if (i_lookup.op == hbp_pkg::OP_FLUSH) begin
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
            end
        end
    end

    // Byte emitter: one byte per beat from the top of the staging word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_advance && (n_res != '0)) begin
            r_left <= n_res;
        end else if (beat) begin
            r_left <= r_left - hbp_pkg::LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && (n_res != '0)) begin
            r_word <= n_load_word;
            r_kind <= n_load_kind;
        end else if (beat) begin
            r_word <= r_word << 8;
        end
    end

    assign o_valid    = (r_left != '0);
    assign o_out_byte = r_word[hbp_pkg::WORD_W-1 -: 8];
    assign o_kind     = r_kind;
    assign o_last     = (r_left == hbp_pkg::LEFT_W'(1));

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the Huffman code bit packer.
`timescale 1ns / 100ps

module tb;

    localparam int SYM_COUNT      = 256;
    localparam int MAX_LEN        = 32;
    localparam int LEN_LIMIT      = (MAX_LEN < 32) ? MAX_LEN : 32;
    localparam int RANDOM_ITEMS   = 335;
    localparam int CALM_ITEMS     = 40;
    localparam int HOLD_START     = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    // One command beat as presented on the input channel.
    typedef struct {
        hbp_pkg::t_opcode            op;
        logic [7:0]                  sym;
        logic [hbp_pkg::CODE_W-1:0]  value;
        logic [hbp_pkg::LEN_W-1:0]   len;
    } t_cmd;

    // One result beat as seen on the output channel.
    typedef struct {
        logic [7:0] data;
        logic       kind;
        logic       last;
    } t_out_beat;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [1:0]                  i_opcode = hbp_pkg::OP_NONE;
    logic [7:0]                  i_symbol = '0;
    logic [hbp_pkg::CODE_W-1:0]  i_code_value = '0;
    logic [hbp_pkg::LEN_W-1:0]   i_code_length = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [7:0]                  o_out_byte;
    logic                        o_kind;
    logic                        o_last;

    t_cmd       symbol_cmds[$];
    t_out_beat  expected_bytes[$];
    logic [7:0] coded_syms[$];

    // Shadow copy of the code table and the bit accumulator.
    logic [hbp_pkg::CODE_W-1:0]  shadow_bits [SYM_COUNT];
    int                          shadow_len  [SYM_COUNT];
    logic [6:0]                  acc_bits = '0;
    int                          acc_count = 0;

    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  rx_cycles = 0;
    int  quiet_cycles = 0;
    logic calm = 1'b0;

    int  mismatches = 0;
    int  n_loads = 0;
    int  n_encodes = 0;
    int  n_flushes = 0;
    int  n_data_bytes = 0;
    int  n_error_results = 0;

    huffman_code_bit_packer #(
        .SYMBOL_COUNT (SYM_COUNT),
        .MAX_CODE_LEN (MAX_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predict the result beats of one accepted command and update the shadow state.
    task automatic pack_symbol(input t_cmd c);
        logic [63:0] acc;
        logic [63:0] mask;
        logic [63:0] shifted;
        logic [15:0] padded;
        int          clen;
        int          total;
        int          nbytes;
        t_out_beat   r;
        case (c.op)
            hbp_pkg::OP_LOAD: begin
                if (c.sym < SYM_COUNT) begin
                    clen = (c.len > LEN_LIMIT) ? LEN_LIMIT : int'(c.len);
                    mask = (64'd1 << clen) - 64'd1;
                    shadow_bits[c.sym] = c.value & mask[hbp_pkg::CODE_W-1:0];
                    shadow_len[c.sym] = clen;
                end
            end
            hbp_pkg::OP_ENCODE: begin
                if (c.sym >= SYM_COUNT || shadow_len[c.sym] == 0) begin
                    // Symbol without a code: error beat, accumulator left alone.
                    r.data = 8'd0;
                    r.kind = hbp_pkg::KIND_ERROR;
                    r.last = 1'b1;
                    expected_bytes.push_back(r);
                end else begin
                    clen = shadow_len[c.sym];
                    acc = ({57'd0, acc_bits} << clen) | {32'd0, shadow_bits[c.sym]};
                    total = acc_count + clen;
                    nbytes = (total / 8 > 4) ? 4 : total / 8;
                    for (int k = 0; k < nbytes; k++) begin
                        shifted = acc >> (total - 8 * (k + 1));
                        r.data = shifted[7:0];
                        r.kind = hbp_pkg::KIND_DATA;
                        r.last = (k == nbytes - 1);
                        expected_bytes.push_back(r);
                    end
                    total = total - 8 * nbytes;
                    mask = (64'd1 << total) - 64'd1;
                    shifted = acc & mask;
                    acc_bits = shifted[6:0];
                    acc_count = total;
                end
            end
            hbp_pkg::OP_FLUSH: begin
                if (acc_count != 0) begin
                    padded = {9'd0, acc_bits} << (8 - acc_count);
                    r.data = padded[7:0];
                    r.kind = hbp_pkg::KIND_DATA;
                    r.last = 1'b1;
                    expected_bytes.push_back(r);
                    acc_bits = '0;
                    acc_count = 0;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_cmd(input hbp_pkg::t_opcode op, input logic [7:0] sym,
                           input logic [hbp_pkg::CODE_W-1:0] value,
                           input logic [hbp_pkg::LEN_W-1:0] len);
        t_cmd c;
        c.op = op;
        c.sym = sym;
        c.value = value;
        c.len = len;
        symbol_cmds.push_back(c);
    endtask

    // Table write with a length mix: mostly short codes, some long, a few overlong or absent.
    task automatic add_random_load();
        logic [7:0]                sym;
        logic [hbp_pkg::LEN_W-1:0] len;
        int                        pick;
        sym = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            len = '0;
        else if (pick < 10)
            len = hbp_pkg::LEN_W'($urandom_range(33, 63));
        else if (pick < 30)
            len = hbp_pkg::LEN_W'($urandom_range(13, 32));
        else
            len = hbp_pkg::LEN_W'($urandom_range(1, 12));
        add_cmd(hbp_pkg::OP_LOAD, sym, $urandom, len);
        if (len != 0)
            coded_syms.push_back(sym);
    endtask

    // Count a failure; only the first few are described.
    task automatic report_mismatch(input string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    // Sender: offers queued commands, with random gaps between beats.
    always @(posedge i_clk) begin : sender
        t_cmd nxt;
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (symbol_cmds.size() != 0) begin
                    nxt = symbol_cmds.pop_front();
                    i_opcode <= nxt.op;
                    i_symbol <= nxt.sym;
                    i_code_value <= nxt.value;
                    i_code_length <= nxt.len;
                    i_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left <= $urandom_range(1, 16);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            calm <= (symbol_cmds.size() < CALM_ITEMS);
        end
    end

    // Receiver: random stall bursts plus one long hold-off to back the block up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rx_cycles <= rx_cycles + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (rx_cycles == HOLD_START) begin
                hold_left <= HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 15);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on every input beat, checks every output beat.
    always @(posedge i_clk) begin : monitor
        t_cmd      c;
        t_out_beat want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                c.op = hbp_pkg::t_opcode'(i_opcode);
                c.sym = i_symbol;
                c.value = i_code_value;
                c.len = i_code_length;
                case (c.op)
                    hbp_pkg::OP_LOAD:   n_loads++;
                    hbp_pkg::OP_ENCODE: n_encodes++;
                    hbp_pkg::OP_FLUSH:  n_flushes++;
                    default: begin
                    end
                endcase
                pack_symbol(c);
            end
            if (o_valid && i_ready) begin
                if (o_kind === hbp_pkg::KIND_ERROR)
                    n_error_results++;
                else
                    n_data_bytes++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf(
                        "Unexpected result: byte %02h kind %0b last %0b",
                        o_out_byte, o_kind, o_last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data || o_kind !== want.kind
                            || o_last !== want.last)
                        report_mismatch($sformatf(
                            "Mismatch: expected byte %02h kind %0b last %0b, got %02h %0b %0b",
                            want.data, want.kind, want.last, o_out_byte, o_kind, o_last));
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         pick;
        int         counted;
        logic [7:0] sym;

        for (int k = 0; k < SYM_COUNT; k++) begin
            shadow_bits[k] = '0;
            shadow_len[k] = 0;
        end

        // Directed part: empty table, bit masking, length saturation, exact
        // byte boundaries, flush with and without pending bits, ignored opcode.
        add_cmd(hbp_pkg::OP_ENCODE, 8'h00, '0, '0);
        add_cmd(hbp_pkg::OP_FLUSH, 8'h00, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'h41, 32'hFFFF_FFFF, 6'd3);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h41, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'hFF, 32'hA5A5_5A5A, 6'd32);
        add_cmd(hbp_pkg::OP_ENCODE, 8'hFF, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'h00, 32'h1234_5678, 6'd63);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h00, '0, '0);
        add_cmd(hbp_pkg::OP_NONE, 8'hAA, 32'hFFFF_FFFF, 6'd63);
        add_cmd(hbp_pkg::OP_LOAD, 8'h80, 32'hFFFF_FFFE, 6'd1);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h80, '0, '0);
        add_cmd(hbp_pkg::OP_FLUSH, 8'h00, '0, '0);
        add_cmd(hbp_pkg::OP_FLUSH, 8'h00, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'h7F, 32'h0000_0001, 6'd33);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h7F, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'h41, 32'hFFFF_FFFF, 6'd0);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h41, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'h55, 32'h0000_00C3, 6'd8);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h55, '0, '0);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h80, '0, '0);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h41, '0, '0);
        add_cmd(hbp_pkg::OP_LOAD, 8'h01, 32'h0000_007F, 6'd7);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h01, '0, '0);
        add_cmd(hbp_pkg::OP_ENCODE, 8'h80, '0, '0);
        add_cmd(hbp_pkg::OP_FLUSH, 8'h00, '0, '0);
        coded_syms = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55, 8'h01};

        // Random part: fill a share of the table, then mostly encode coded symbols.
        counted = 0;
        for (int k = 0; k < 24; k++) begin
            add_random_load();
            counted++;
        end
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                add_cmd(hbp_pkg::OP_NONE, 8'($urandom_range(0, 255)), $urandom,
                        hbp_pkg::LEN_W'($urandom_range(0, 63)));
            end else if (pick < 18) begin
                add_random_load();
                counted++;
            end else if (pick < 28) begin
                add_cmd(hbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                        hbp_pkg::LEN_W'($urandom_range(0, 63)));
                counted++;
            end else begin
                if ($urandom_range(0, 9) != 0)
                    sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
                else
                    sym = 8'($urandom_range(0, 255));
                add_cmd(hbp_pkg::OP_ENCODE, sym, $urandom,
                        hbp_pkg::LEN_W'($urandom_range(0, 63)));
                counted++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last beat in and every predicted beat out, then drain.
        do
            @(posedge i_clk);
        while (symbol_cmds.size() != 0 || i_valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d loads, %0d encodes and %0d flushes through the packer,",
                 n_loads, n_encodes, n_flushes);
        $display("checking %0d packed bytes and %0d no-code errors; %0d mismatches.",
                 n_data_bytes, n_error_results, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
